// File: src/qse_pkg.sv
// package for the quicksort engine: widths, cell opcodes, cell control type, compare function
`default_nettype none
package qse_pkg;

  localparam int QSE_MAX_ELEMENTS = 64;
  localparam int QSE_DATA_W       = 32;

  // cell opcodes
  localparam logic [2:0] OP_HOLD  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_EVEN  = 3'd2;
  localparam logic [2:0] OP_ODD   = 3'd3;
  localparam logic [2:0] OP_SHIFT = 3'd4;

  typedef logic signed [QSE_DATA_W-1:0] data_t;

  typedef struct packed {
    logic [2:0] op;
    logic       desc;
  } cell_ctrl_t;

  // true when element a must be placed after element b; empty slots go last
  function automatic logic comes_after(input data_t a, input logic a_vld,
                                       input data_t b, input logic b_vld,
                                       input logic desc);
    logic res;
    if (!a_vld) begin
      res = b_vld;
    end else if (!b_vld) begin
      res = 1'b0;
    end else begin
      res = desc ? (a < b) : (a > b);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: src/qse_in_if.sv
// input channel interface: one frame element per beat
`default_nettype none
interface qse_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  value;
  logic                is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface
`default_nettype wire

// File: src/qse_out_if.sv
// result channel interface: one sorted element per beat
`default_nettype none
interface qse_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  sorted_value;
  logic                last_out;

  modport source (output valid, output sorted_value, output last_out, input ready);
  modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface
`default_nettype wire

// File: src/quicksort_engine.sv
// top level of the frame sorter: control sequencer and the row of sorter cells
`default_nettype none
// Frame sorter for signed 32-bit elements. A frame arrives on in_ch one element
// per beat, the final beat flagged by is_last; elements beyond MAX_ELEMENTS are
// dropped (a dropped final beat still ends the frame). The frame is then sorted
// and sent on out_ch one element per beat in ascending order, or descending when
// the cfg_wdata bit written through cfg_we is 1 (the bit is sampled when the
// sort starts). Storage is a row of MAX_ELEMENTS cells: loading shifts each
// element in at cell 0, the sort is an odd-even transposition pass in which
// each phase compares and swaps alternate cell pairs (even, then odd) in
// parallel, and results leave from cell 0 as the row shifts back toward it on
// each accepted output beat. in_ch is not ready during the sort and the output
// phase.
module quicksort_engine #(
  parameter int MAX_ELEMENTS = qse_pkg::QSE_MAX_ELEMENTS
) (
  input  wire       clk,
  input  wire       rst_n,
  qse_in_if.sink    in_ch,
  qse_out_if.source out_ch,
  input  wire       cfg_we,
  input  wire       cfg_wdata
);
  import qse_pkg::*;

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int PH_W  = $clog2(MAX_ELEMENTS);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       st_r, st_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PH_W-1:0]  phase_r, phase_nxt;
  logic             desc_cfg_r;
  logic             desc_r, desc_nxt;

  cell_ctrl_t ctrl;
  data_t      cell_value [MAX_ELEMENTS];
  logic       cell_valid [MAX_ELEMENTS];

  logic in_beat, out_beat, room;

  // configuration register, written whenever the enable is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_cfg_r <= 1'b0;
    end else if (cfg_we) begin
      desc_cfg_r <= cfg_wdata;
    end
  end

  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_beat = out_ch.valid && out_ch.ready;
  assign room     = count_r < CNT_W'(MAX_ELEMENTS);

  // sequencer: load, fixed-length sort, then drain from cell 0
  always_comb begin
    st_nxt    = st_r;
    count_nxt = count_r;
    phase_nxt = phase_r;
    desc_nxt  = desc_r;
    ctrl.op   = OP_HOLD;
    unique case (st_r)
      ST_LOAD: begin
        if (in_beat) begin
          if (room) begin
            ctrl.op   = OP_LOAD;
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_ch.is_last) begin
            st_nxt    = ST_SORT;
            phase_nxt = '0;
            // sample the order at sort start
            desc_nxt  = desc_cfg_r;
          end
        end
      end
      ST_SORT: begin
        ctrl.op   = phase_r[0] ? OP_ODD : OP_EVEN;
        phase_nxt = phase_r + PH_W'(1);
        if (phase_r == PH_W'(MAX_ELEMENTS - 1)) begin
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_beat) begin
          ctrl.op   = OP_SHIFT;
          count_nxt = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            st_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        st_nxt = ST_LOAD;
      end
    endcase
    ctrl.desc = desc_r;
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    desc_r  <= desc_nxt;
    if (!rst_n) begin
      st_r    <= ST_LOAD;
      count_r <= '0;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
    end
  end

  // row of cells; cell 0 takes new elements and feeds the output
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    data_t lv, rv;
    logic  lvld, rvld;

    if (i == 0) begin : g_first
      assign lv   = in_ch.value;
      assign lvld = 1'b1;
    end else begin : g_mid_l
      assign lv   = cell_value[i-1];
      assign lvld = cell_valid[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_last
      // the far end refills with empty slots while shifting out
      assign rv   = '0;
      assign rvld = 1'b0;
    end else begin : g_mid_r
      assign rv   = cell_value[i+1];
      assign rvld = cell_valid[i+1];
    end

    qse_cell #(
      .IDX (i),
      .N   (MAX_ELEMENTS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_value  (lv),
      .left_valid  (lvld),
      .right_value (rv),
      .right_valid (rvld),
      .value       (cell_value[i]),
      .valid       (cell_valid[i])
    );
  end

  assign in_ch.ready         = (st_r == ST_LOAD);
  assign out_ch.valid        = (st_r == ST_EMIT);
  assign out_ch.sorted_value = cell_value[0];
  assign out_ch.last_out     = (count_r == CNT_W'(1));

`ifndef SYNTHESIS
  // the head cell holds a real element whenever a result is offered
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> cell_valid[0])
    else $error("result offered from an empty head cell");

  // the final result has no element behind it in cell 1
  a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last_out) |-> !cell_valid[1])
    else $error("elements remain behind the final result");

  // a final input beat always starts the sort
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_ch.is_last) |=> (st_r == ST_SORT))
    else $error("final beat did not start the sort");

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input and output active together");
`endif

endmodule
`default_nettype wire

// File: src/qse_cell.sv
// one sorter cell: holds an element, loads from the left, shifts out to the left,
// and does compare-exchange with a neighbor on even/odd phases
`default_nettype none
module qse_cell #(
  parameter int IDX = 0,
  parameter int N   = 64
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  qse_pkg::cell_ctrl_t  ctrl,
  input  qse_pkg::data_t       left_value,
  input  wire                  left_valid,
  input  qse_pkg::data_t       right_value,
  input  wire                  right_valid,
  output qse_pkg::data_t       value,
  output logic                 valid
);
  import qse_pkg::*;

  localparam bit IS_ODD    = (IDX % 2) == 1;
  localparam bit HAS_LEFT  = IDX > 0;
  localparam bit HAS_RIGHT = IDX < N - 1;

  data_t value_r, value_nxt;
  logic  valid_r, valid_nxt;
  logic  pair_right, pair_left;
  logic  swap_right, swap_left;

  always_comb begin
    pair_right = HAS_RIGHT && (((ctrl.op == OP_EVEN) && !IS_ODD) ||
                               ((ctrl.op == OP_ODD) && IS_ODD));
    pair_left  = HAS_LEFT && (((ctrl.op == OP_EVEN) && IS_ODD) ||
                              ((ctrl.op == OP_ODD) && !IS_ODD));
    swap_right = comes_after(value_r, valid_r, right_value, right_valid, ctrl.desc);
    swap_left  = comes_after(left_value, left_valid, value_r, valid_r, ctrl.desc);
  end

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    unique case (ctrl.op)
      OP_LOAD: begin
        value_nxt = left_value;
        valid_nxt = left_valid;
      end
      OP_SHIFT: begin
        value_nxt = right_value;
        valid_nxt = right_valid;
      end
      OP_EVEN, OP_ODD: begin
        if (pair_right && swap_right) begin
          value_nxt = right_value;
          valid_nxt = right_valid;
        end else if (pair_left && swap_left) begin
          value_nxt = left_value;
          valid_nxt = left_valid;
        end
      end
      default: begin
        value_nxt = value_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule
`default_nettype wire
